[rtl/gcol_pkg.sv]
// ----------------------------------------------------------------------------
// gcol_pkg
// Shared types and constants for the grid cell owner lookup core.
// ----------------------------------------------------------------------------
`default_nettype none
package gcol_pkg;
    localparam int MAX_GRID_DEF      = 16;
    localparam int OWNER_ENTRIES_DEF = 4096;

    localparam logic [1:0] MODE_LOOKUP = 2'd0;
    localparam logic [1:0] MODE_SPLIT  = 2'd1;
    localparam logic [1:0] MODE_OWNER  = 2'd2;
    localparam logic [1:0] MODE_BOX    = 2'd3;

    localparam logic [2:0] REG_GRID_X     = 3'd0;
    localparam logic [2:0] REG_GRID_Y     = 3'd1;
    localparam logic [2:0] REG_GRID_Z     = 3'd2;
    localparam logic [2:0] REG_NONUNIFORM = 3'd3;
    localparam logic [2:0] REG_FRACTIONAL = 3'd4;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic [1:0]         axis;
        logic [11:0]        entry_index;
        logic signed [31:0] entry_value;
        logic [31:0]        inverse_length;
    } t_in_item;

    typedef struct packed {
        logic [11:0] owner;
        logic [3:0]  cell_x;
        logic [3:0]  cell_y;
        logic [3:0]  cell_z;
    } t_out_item;
endpackage
`default_nettype wire

[rtl/grid_cell_owner_lookup_core.sv]
// ----------------------------------------------------------------------------
// grid_cell_owner_lookup_core
// Maps a point to its grid cell and the owner id stored for that cell.
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  input    | i_start / o_busy        | i_item (t_in_item)
//  result   | o_result_valid (strobe) | o_result (t_out_item)
//  config   | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One beat enters per cycle; o_busy stays low. A lookup strobes its result
// after two fraction stages, the bounds stage, the bisection stages, two
// index stages, the owner RAM read and the output register. Table writes
// are delayed to their read points. Synchronous active-low reset clears
// control and box registers; split points and owners are undefined until
// written. No stalls.
// ----------------------------------------------------------------------------
`default_nettype none
module grid_cell_owner_lookup_core #(
    parameter int MAX_GRID      = gcol_pkg::MAX_GRID_DEF,
    parameter int OWNER_ENTRIES = gcol_pkg::OWNER_ENTRIES_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_start,
    output logic                 o_busy,
    input  wire gcol_pkg::t_in_item i_item,
    output logic                 o_result_valid,
    output gcol_pkg::t_out_item  o_result,
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire [2:0]            i_cfg_index,
    input  wire [31:0]           i_cfg_data
);
    localparam int CW    = $clog2(MAX_GRID + 1);
    localparam int SW    = $clog2(MAX_GRID + 1);
    localparam int OW    = (OWNER_ENTRIES > 1) ? $clog2(OWNER_ENTRIES) : 1;
    localparam int STEPS = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;
    localparam int AXL   = 3 + STEPS;  // axis unit latency
    localparam int IW    = 3 * CW + 1;
    localparam int OWD   = AXL + 2;    // accept to owner RAM read

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    logic [4:0] r_gx, r_gy, r_gz;
    logic       r_nonuni, r_fracm;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gx <= 5'd1; r_gy <= 5'd1; r_gz <= 5'd1;
            r_nonuni <= 1'b0; r_fracm <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                gcol_pkg::REG_GRID_X:     r_gx <= i_cfg_data[4:0];
                gcol_pkg::REG_GRID_Y:     r_gy <= i_cfg_data[4:0];
                gcol_pkg::REG_GRID_Z:     r_gz <= i_cfg_data[4:0];
                gcol_pkg::REG_NONUNIFORM: r_nonuni <= i_cfg_data[0];
                gcol_pkg::REG_FRACTIONAL: r_fracm <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // effective grid: zero as one, clamp to MAX_GRID
    function automatic logic [CW-1:0] eff_grid(input logic [4:0] g);
        if (g == 5'd0) return CW'(1);
        if (32'(g) > MAX_GRID) return CW'(MAX_GRID);
        return CW'(g);
    endfunction
    logic [CW-1:0] w_g [3];
    assign w_g[0] = eff_grid(r_gx);
    assign w_g[1] = eff_grid(r_gy);
    assign w_g[2] = eff_grid(r_gz);

    // box registers
    logic signed [31:0] r_origin [3];
    logic [31:0]        r_inv [3];
    logic               w_acc;
    assign w_acc = i_start;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_origin[a] <= '0;
                r_inv[a]    <= '0;
            end
        end else if (w_acc && i_item.mode == gcol_pkg::MODE_BOX && i_item.axis != 2'd3) begin
            r_origin[i_item.axis] <= i_item.entry_value;
            r_inv[i_item.axis]    <= i_item.inverse_length;
        end
    end

    // split writes: a delay line lands each one just before the compare
    // stage of the first lookup that follows it
    logic               w_split_ok;
    logic [2:0]         r_sw_we [2];
    logic [SW-1:0]      r_sw_idx [2];
    logic signed [31:0] r_sw_val [2];
    assign w_split_ok = w_acc && i_item.mode == gcol_pkg::MODE_SPLIT
                        && 32'(i_item.entry_index) <= MAX_GRID;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw_we[0] <= '0;
            r_sw_we[1] <= '0;
        end else begin
            for (int a = 0; a < 3; a++) begin
                r_sw_we[0][a] <= w_split_ok && i_item.axis == 2'(a);
            end
            r_sw_we[1] <= r_sw_we[0];
        end
        r_sw_idx[0] <= SW'(i_item.entry_index);
        r_sw_val[0] <= i_item.entry_value;
        r_sw_idx[1] <= r_sw_idx[0];
        r_sw_val[1] <= r_sw_val[0];
    end

    // axis units
    logic signed [31:0] w_coord [3];
    logic [CW-1:0]      w_cell [3];
    assign w_coord[0] = i_item.coord_x;
    assign w_coord[1] = i_item.coord_y;
    assign w_coord[2] = i_item.coord_z;
    for (genvar a = 0; a < 3; a++) begin : g_axis
        gcol_axis #(.MAX_GRID(MAX_GRID)) u_axis (
            .i_clk      (i_clk),
            .i_nonuni   (r_nonuni),
            .i_frac_mode(r_fracm),
            .i_grid     (w_g[a]),
            .i_origin   (r_origin[a]),
            .i_inv      (r_inv[a]),
            .i_split_we (r_sw_we[1][a]),
            .i_split_idx(r_sw_idx[1]),
            .i_split_val(r_sw_val[1]),
            .i_coord    (w_coord[a]),
            .o_cell     (w_cell[a])
        );
    end

    // lookup valid shift line
    logic r_vld [AXL];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < AXL; k++) r_vld[k] <= 1'b0;
        end else begin
            r_vld[0] <= w_acc && i_item.mode == gcol_pkg::MODE_LOOKUP;
            for (int k = 1; k < AXL; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // owner writes: delayed to the RAM read point of lookups in flight
    logic          r_ow_we [OWD];
    logic [OW-1:0] r_ow_addr [OWD];
    logic [11:0]   r_ow_data [OWD];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < OWD; k++) r_ow_we[k] <= 1'b0;
        end else begin
            r_ow_we[0] <= w_acc && i_item.mode == gcol_pkg::MODE_OWNER
                          && 32'(i_item.entry_index) < OWNER_ENTRIES;
            for (int k = 1; k < OWD; k++) r_ow_we[k] <= r_ow_we[k-1];
        end
        r_ow_addr[0] <= OW'(i_item.entry_index);
        r_ow_data[0] <= i_item.entry_value[11:0];
        for (int k = 1; k < OWD; k++) begin
            r_ow_addr[k] <= r_ow_addr[k-1];
            r_ow_data[k] <= r_ow_data[k-1];
        end
    end

    // index stage 1: cx * gy + cy
    logic            r_v1, r_v2, r_v3;
    logic [2*CW:0]   r_i1;
    logic [CW-1:0]   r_cx1, r_cy1, r_cz1, r_cx2, r_cy2, r_cz2, r_cx3, r_cy3, r_cz3;
    logic [IW-1:0]   r_i2;
    logic            r_oob3;
    logic [11:0]     w_rdata;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0; o_result_valid <= 1'b0;
        end else begin
            r_v1 <= r_vld[AXL-1];
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            o_result_valid <= r_v3;
        end
        r_i1  <= (2*CW+1)'(w_cell[0]) * (2*CW+1)'(w_g[1]) + (2*CW+1)'(w_cell[1]);
        r_cx1 <= w_cell[0]; r_cy1 <= w_cell[1]; r_cz1 <= w_cell[2];
        // index stage 2: * gz + cz
        r_i2  <= IW'(r_i1) * IW'(w_g[2]) + IW'(r_cz1);
        r_cx2 <= r_cx1; r_cy2 <= r_cy1; r_cz2 <= r_cz1;
        // RAM read stage
        r_oob3 <= 32'(r_i2) >= OWNER_ENTRIES;
        r_cx3 <= r_cx2; r_cy3 <= r_cy2; r_cz3 <= r_cz2;
        // output register
        o_result.owner  <= r_oob3 ? 12'd0 : w_rdata;
        o_result.cell_x <= 4'(r_cx3);
        o_result.cell_y <= 4'(r_cy3);
        o_result.cell_z <= 4'(r_cz3);
    end

    // owner table
    gcol_ram #(.WIDTH(12), .DEPTH(OWNER_ENTRIES)) u_owner (
        .i_clk  (i_clk),
        .i_we   (r_ow_we[OWD-1]),
        .i_waddr(r_ow_addr[OWD-1]),
        .i_wdata(r_ow_data[OWD-1]),
        .i_raddr(OW'(r_i2)),
        .o_rdata(w_rdata)
    );
endmodule
`default_nettype wire

[rtl/gcol_ram.sv]
// ----------------------------------------------------------------------------
// gcol_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module gcol_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[rtl/gcol_axis.sv]
// ----------------------------------------------------------------------------
// gcol_axis
// One axis: fraction, then uniform scaling or split point bisection, pipelined.
// Stage 1: diff and product. Stage 2: fraction. Stage 3..: cell.
// All split points are compared in stage 3; bisection works on the compare bits.
// ----------------------------------------------------------------------------
`default_nettype none
module gcol_axis #(
    parameter int MAX_GRID = gcol_pkg::MAX_GRID_DEF,
    localparam int CW = $clog2(MAX_GRID + 1),
    localparam int SW = $clog2(MAX_GRID + 1)
) (
    input  wire                 i_clk,
    input  wire                 i_nonuni,
    input  wire                 i_frac_mode,
    input  wire [CW-1:0]        i_grid,
    input  wire signed [31:0]   i_origin,
    input  wire [31:0]          i_inv,
    input  wire                 i_split_we,
    input  wire [SW-1:0]        i_split_idx,
    input  wire signed [31:0]   i_split_val,
    input  wire signed [31:0]   i_coord,
    output logic [CW-1:0]       o_cell
);
    localparam int STEPS = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;

    // split point registers, all compared in stage 3
    logic signed [31:0] r_split [MAX_GRID+1];
    always_ff @(posedge i_clk) begin
        if (i_split_we) begin
            r_split[i_split_idx] <= i_split_val;
        end
    end

    // stage 1: magnitude of difference times inverse length
    logic signed [32:0] w_diff;
    logic [32:0]        w_mag;
    logic [64:0]        r_prod;
    logic               r_neg1, r_fm1;
    logic signed [31:0] r_coord1;
    assign w_diff = 33'(i_coord) - 33'(i_origin);
    assign w_mag  = w_diff[32] ? 33'(-w_diff) : w_diff;
    always_ff @(posedge i_clk) begin
        r_prod   <= 65'(w_mag) * 65'(i_inv);
        r_neg1   <= w_diff[32];
        r_fm1    <= i_frac_mode;
        r_coord1 <= i_coord;
    end

    // stage 2: round toward minus infinity and saturate, or pass the coordinate in fractional mode
    logic [40:0]        w_q;
    logic signed [31:0] n_frac, r_frac;
    assign w_q = r_neg1 ? 41'((r_prod + 65'h00FFFFFF) >> 24) : 41'(r_prod >> 24);
    always_comb begin
        if (r_fm1) begin
            n_frac = r_coord1;
        end else if (r_neg1) begin
            n_frac = (w_q > 41'h080000000) ? 32'sh80000000 : 32'(-w_q);
        end else begin
            n_frac = (w_q > 41'h07FFFFFFF) ? 32'sh7FFFFFFF : w_q[31:0];
        end
    end
    always_ff @(posedge i_clk) begin
        r_frac <= n_frac;
    end

    // stage 3: split compares, uniform cell and search bounds
    logic [CW-1:0]      w_last;
    logic [CW+31:0]     w_scaled;
    logic [CW+15:0]     w_ucell;
    logic [CW-1:0]      n_uni;
    logic [MAX_GRID:0]  w_ge;
    logic [CW-1:0]      r_lo [STEPS+1];
    logic [CW-1:0]      r_hi [STEPS+1];
    logic               r_done [STEPS+1];
    logic [MAX_GRID:0]  r_ge [STEPS+1];
    assign w_last   = i_grid - CW'(1);
    assign w_scaled = (CW+32)'(i_grid) * (CW+32)'($unsigned(r_frac));
    assign w_ucell  = w_scaled[CW+31:16];
    always_comb begin
        for (int i = 0; i <= MAX_GRID; i++) begin
            w_ge[i] = (r_frac >= r_split[i]);
        end
    end
    always_comb begin
        if (r_frac[31]) begin
            n_uni = '0;
        end else if (w_ucell >= (CW+16)'(i_grid)) begin
            n_uni = w_last;
        end else begin
            n_uni = w_ucell[CW-1:0];
        end
    end
    always_ff @(posedge i_clk) begin
        r_ge[0] <= w_ge;
        if (!i_nonuni) begin
            r_done[0] <= 1'b1;
            r_lo[0]   <= n_uni;
            r_hi[0]   <= n_uni;
        end else if (!w_ge[0]) begin
            r_done[0] <= 1'b1;
            r_lo[0]   <= '0;
            r_hi[0]   <= '0;
        end else if (w_ge[w_last]) begin
            r_done[0] <= 1'b1;
            r_lo[0]   <= w_last;
            r_hi[0]   <= w_last;
        end else begin
            r_done[0] <= 1'b0;
            r_lo[0]   <= '0;
            r_hi[0]   <= w_last;
        end
    end

    // bisection stages, one halving per stage
    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [CW-1:0] w_mid;
        assign w_mid = CW'(({1'b0, r_lo[k]} + {1'b0, r_hi[k]}) >> 1);
        always_ff @(posedge i_clk) begin
            r_ge[k+1]   <= r_ge[k];
            r_done[k+1] <= r_done[k];
            r_lo[k+1]   <= r_lo[k];
            r_hi[k+1]   <= r_hi[k];
            if (!r_done[k] && (r_lo[k] + CW'(1) < r_hi[k])) begin
                if (!r_ge[k][w_mid]) begin
                    r_hi[k+1] <= w_mid;
                end else begin
                    r_lo[k+1] <= w_mid;
                end
            end
        end
    end

    // final: done carries lo, else midpoint of adjacent pair
    logic [CW-1:0] w_fmid;
    assign w_fmid = CW'(({1'b0, r_lo[STEPS]} + {1'b0, r_hi[STEPS]}) >> 1);
    assign o_cell = r_done[STEPS] ? r_lo[STEPS] : w_fmid;
endmodule
`default_nettype wire

[tb/grid_cell_owner_lookup_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_cell_owner_lookup_core_test
// Self-checking bench for the grid cell owner lookup core. Loads the split
// point and owner tables, then runs directed corner beats and random lookup
// and table-write traffic under several grid and layout settings. A local
// cell/owner predictor forms the expected result of every lookup beat, and a
// monitor checks each result strobe against the oldest one in order.
// ----------------------------------------------------------------------------
module grid_cell_owner_lookup_core_test;
    import gcol_pkg::*;

    localparam int          SPLIT_DEPTH  = MAX_GRID_DEF + 1;
    localparam logic [1:0]  AXIS_X       = 2'd0;
    localparam logic [1:0]  AXIS_Z       = 2'd2;
    localparam logic [1:0]  AXIS_NONE    = 2'd3;
    localparam logic [2:0]  REG_SPARE_LO = 3'd5;
    localparam logic [2:0]  REG_SPARE_HI = 3'd7;
    localparam int          DRAIN_CYCLES = 24;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          RAND_PER_SEG = 150;
    localparam int          OWNER_FILL   = 512;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_start = 1'b0;
    t_in_item  i_item = '0;
    logic      i_cfg_valid = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic      o_busy;
    logic      o_result_valid;
    t_out_item o_result;
    logic      o_cfg_ready;

    grid_cell_owner_lookup_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_item(i_item), .o_result_valid(o_result_valid), .o_result(o_result),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // predictor copy of block state
    logic [4:0]  grid_reg[3];
    logic        nonuniform_reg;
    logic        fractional_reg;
    longint      split_mem[3][SPLIT_DEPTH];
    longint      box_origin[3];
    logic [31:0] box_inv_len[3];
    logic [11:0] owner_mem[OWNER_ENTRIES_DEF];

    t_in_item  pending_beats[$];
    t_out_item owed_results[$];
    int        idle_pct = 29;
    int        errors = 0;
    int        lookups_checked = 0;
    int        beats_sent = 0;
    int        cycle_count = 0;

    function automatic int eff_grid(logic [4:0] g);
        if (g == 0) return 1;
        if (g > MAX_GRID_DEF) return MAX_GRID_DEF;
        return g;
    endfunction

    // box fraction in Q16.16, floor rounding and saturation
    function automatic longint axis_fraction(logic signed [31:0] c, int a);
        longint      diff, f;
        logic [63:0] mag;
        logic [64:0] prod;
        if (fractional_reg) return longint'(c);
        diff = longint'(c) - box_origin[a];
        mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
        prod = {1'b0, mag * {32'b0, box_inv_len[a]}};
        if (diff < 0) f = -longint'((prod + 65'hFFFFFF) >> 24);
        else          f = longint'(prod >> 24);
        if (f > 64'sd2147483647)  f = 64'sd2147483647;
        if (f < -64'sd2147483648) f = -64'sd2147483648;
        return f;
    endfunction

    function automatic int axis_cell(logic signed [31:0] c, int g, int a);
        longint v, cell_idx;
        int     lo, hi, mid;
        v = axis_fraction(c, a);
        if (nonuniform_reg) begin
            lo = 0;
            hi = g - 1;
            if (v < split_mem[a][lo]) return lo;
            if (v >= split_mem[a][hi]) return hi;
            mid = (lo + hi) / 2;
            while (lo + 1 < hi) begin
                if (v < split_mem[a][mid]) hi = mid;
                else lo = mid;
                mid = (lo + hi) / 2;
            end
            return mid;
        end
        if (v < 0) return 0;
        cell_idx = (longint'(g) * v) >>> 16;
        if (cell_idx >= g) cell_idx = g - 1;
        return int'(cell_idx);
    endfunction

    // apply one accepted beat; lookups push their expected result
    task automatic apply_beat(t_in_item it);
        int        gx, gy, gz, cx, cy, cz, oi;
        t_out_item r;
        case (it.mode)
            MODE_SPLIT: begin
                if (it.axis != AXIS_NONE && it.entry_index <= MAX_GRID_DEF)
                    split_mem[it.axis][it.entry_index] = longint'(it.entry_value);
            end
            MODE_OWNER: owner_mem[it.entry_index] = it.entry_value[11:0];
            MODE_BOX: begin
                if (it.axis != AXIS_NONE) begin
                    box_origin[it.axis]  = longint'(it.entry_value);
                    box_inv_len[it.axis] = it.inverse_length;
                end
            end
            default: begin
                gx = eff_grid(grid_reg[0]);
                gy = eff_grid(grid_reg[1]);
                gz = eff_grid(grid_reg[2]);
                cx = axis_cell(it.coord_x, gx, 0);
                cy = axis_cell(it.coord_y, gy, 1);
                cz = axis_cell(it.coord_z, gz, 2);
                oi = (cx * gy + cy) * gz + cz;
                r.owner  = (oi < OWNER_ENTRIES_DEF) ? owner_mem[oi] : 12'd0;
                r.cell_x = cx[3:0];
                r.cell_y = cy[3:0];
                r.cell_z = cz[3:0];
                owed_results.push_back(r);
            end
        endcase
    endtask

    // driver: one beat per handshake, random idle cycles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (i_start && !o_busy) begin
                apply_beat(i_item);
                beats_sent++;
            end
            if (i_start && o_busy) begin
                i_start <= 1'b1;
            end else if (pending_beats.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                i_start <= 1'b1;
                i_item  <= pending_beats.pop_front();
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // monitor: compare each result strobe with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (owed_results.size() == 0) begin
                $display("%0t: unexpected result owner=%0d cell=%0d,%0d,%0d", $time,
                         o_result.owner, o_result.cell_x, o_result.cell_y, o_result.cell_z);
                errors++;
            end else begin
                if (o_result !== owed_results[0]) begin
                    $display("%0t: mismatch exp owner=%0d cell=%0d,%0d,%0d got owner=%0d cell=%0d,%0d,%0d",
                             $time, owed_results[0].owner, owed_results[0].cell_x,
                             owed_results[0].cell_y, owed_results[0].cell_z, o_result.owner,
                             o_result.cell_x, o_result.cell_y, o_result.cell_z);
                    errors++;
                end
                void'(owed_results.pop_front());
                lookups_checked++;
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("grid_cell_owner_lookup_core_test: FAIL");
            $finish;
        end
    end

    function automatic t_in_item random_beat();
        t_in_item it;
        it = ($bits(t_in_item))'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                  $urandom, $urandom});
        return it;
    endfunction

    function automatic logic signed [31:0] pick_coord(logic frac);
        if ($urandom_range(0, 9) == 0) return $urandom;
        if (frac) return $urandom_range(0, 32'h18000) - 32'h4000;
        return $urandom_range(0, 32'h80000) - 32'h20000;
    endfunction

    function automatic t_in_item lookup_beat(logic frac);
        t_in_item it;
        it         = random_beat();
        it.mode    = MODE_LOOKUP;
        it.coord_x = pick_coord(frac);
        it.coord_y = pick_coord(frac);
        it.coord_z = pick_coord(frac);
        return it;
    endfunction

    function automatic t_in_item write_beat(logic [1:0] m, logic [1:0] ax, int idx,
                                            logic [31:0] val, logic [31:0] inv);
        t_in_item it;
        it                = random_beat();
        it.mode           = m;
        it.axis           = ax;
        it.entry_index    = idx[11:0];
        it.entry_value    = val;
        it.inverse_length = inv;
        return it;
    endfunction

    // box with origin near zero and length of half a unit to four units
    function automatic t_in_item sane_box(logic [1:0] ax);
        logic [31:0] span;
        span = $urandom_range(32'h8000, 32'h40000);
        return write_beat(MODE_BOX, ax, $urandom, $urandom_range(0, 32'h20000) - 32'h10000,
                          32'((64'd1 << 40) / span));
    endfunction

    // wait until the block has drained every beat
    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_beats.size() > 0 || i_start || owed_results.size() > 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_GRID_X:     grid_reg[0] = data[4:0];
            REG_GRID_Y:     grid_reg[1] = data[4:0];
            REG_GRID_Z:     grid_reg[2] = data[4:0];
            REG_NONUNIFORM: nonuniform_reg = data[0];
            REG_FRACTIONAL: fractional_reg = data[0];
            default: ;
        endcase
    endtask

    // ascending split points spaced 1/g apart from zero, plus a box per axis
    task automatic load_layout(int g);
        for (int a = 0; a < 3; a++) begin
            for (int s = 0; s < SPLIT_DEPTH; s++)
                pending_beats.push_back(write_beat(MODE_SPLIT, a[1:0], s,
                    s * (32'h10000 / g) + $urandom_range(0, 32'h800) - 32'h400, $urandom));
            pending_beats.push_back(sane_box(a[1:0]));
        end
    endtask

    task automatic random_traffic(int count);
        int       r;
        t_in_item it;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                it = lookup_beat(fractional_reg);
            end else if (r < 82) begin
                it = write_beat(MODE_OWNER, $urandom, $urandom, $urandom, $urandom);
            end else if (r < 92) begin
                it = write_beat(MODE_SPLIT, $urandom_range(0, 3), $urandom_range(0, 20),
                                ($urandom_range(0, 3) == 0) ? $urandom
                                                            : $urandom_range(0, 32'h10000),
                                $urandom);
            end else if ($urandom_range(0, 4) == 0) begin
                it = write_beat(MODE_BOX, $urandom_range(0, 3), $urandom, $urandom, $urandom);
            end else begin
                it = sane_box($urandom_range(0, 2));
            end
            pending_beats.push_back(it);
        end
    endtask

    // grids keep every cell index inside the filled part of the owner table
    int seg_cfg[6][5] = '{
        '{1, 1, 1, 0, 0}, '{8, 8, 8, 1, 0},   '{5, 3, 7, 0, 1},
        '{16, 1, 9, 1, 1}, '{0, 31, 2, 0, 0},  '{4, 4, 4, 1, 0}
    };

    initial begin
        int g;
        t_in_item it;
        grid_reg       = '{5'd1, 5'd1, 5'd1};
        nonuniform_reg = 1'b0;
        fractional_reg = 1'b0;
        box_origin     = '{0, 0, 0};
        box_inv_len    = '{32'd0, 32'd0, 32'd0};
        foreach (split_mem[a, s]) split_mem[a][s] = 0;
        foreach (owner_mem[k]) owner_mem[k] = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // fill every owner entry a lookup can reach and all split points first
        for (int k = 0; k < OWNER_FILL; k++)
            pending_beats.push_back(write_beat(MODE_OWNER, $urandom, k, $urandom, $urandom));
        load_layout(1);

        // directed corners: coordinate extremes, ignored writes, saturation
        pending_beats.push_back(lookup_beat(1'b0));
        it = lookup_beat(1'b0);
        it.coord_x = 32'sh8000_0000; it.coord_y = 32'sh7FFF_FFFF; it.coord_z = '0;
        pending_beats.push_back(it);
        pending_beats.push_back(write_beat(MODE_SPLIT, AXIS_NONE, 0, $urandom, $urandom));
        pending_beats.push_back(write_beat(MODE_SPLIT, AXIS_X, 17, $urandom, $urandom));
        pending_beats.push_back(write_beat(MODE_SPLIT, AXIS_Z, 4095, $urandom, $urandom));
        pending_beats.push_back(write_beat(MODE_BOX, AXIS_NONE, 0, $urandom, $urandom));
        pending_beats.push_back(write_beat(MODE_OWNER, 0, 4095, 32'hFFFF_FFFF, 0));
        pending_beats.push_back(write_beat(MODE_BOX, AXIS_X, 0, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
        pending_beats.push_back(write_beat(MODE_BOX, 2'd1, 0, 32'h8000_0000, 32'hFFFF_FFFF));
        pending_beats.push_back(write_beat(MODE_BOX, AXIS_Z, 0, 32'h0, 32'hFFFF_FFFF));
        it = lookup_beat(1'b0);
        it.coord_x = 32'sh8000_0000; it.coord_y = 32'sh7FFF_FFFF; it.coord_z = 32'sh0000_0001;
        pending_beats.push_back(it);
        it.coord_x = 32'sh7FFF_FFFF; it.coord_y = 32'sh8000_0000; it.coord_z = 32'shFFFF_FFFF;
        pending_beats.push_back(it);
        for (int a = 0; a < 3; a++) pending_beats.push_back(sane_box(a[1:0]));
        wait_idle();

        // unknown register indices must not disturb anything
        for (logic [2:0] r = REG_SPARE_LO; r != 3'd0 && r <= REG_SPARE_HI; r++)
            write_reg(r, $urandom);

        for (int seg = 0; seg < 6; seg++) begin
            if (seg == 5)
                for (int f = 0; f < 5; f++)
                    seg_cfg[seg][f] = (f < 3) ? $urandom_range(0, 8) : $urandom_range(0, 1);
            write_reg(REG_GRID_X, {$urandom, 5'd0} | seg_cfg[seg][0][4:0]);
            write_reg(REG_GRID_Y, {$urandom, 5'd0} | seg_cfg[seg][1][4:0]);
            write_reg(REG_GRID_Z, {$urandom, 5'd0} | seg_cfg[seg][2][4:0]);
            write_reg(REG_NONUNIFORM, {$urandom, 1'b0} | seg_cfg[seg][3][0]);
            write_reg(REG_FRACTIONAL, {$urandom, 1'b0} | seg_cfg[seg][4][0]);
            idle_pct = (seg < 2) ? 29 : (seg < 4) ? 48 : 0;
            g = eff_grid(grid_reg[0]);
            load_layout(g);
            random_traffic(RAND_PER_SEG);
            // sender holds off until every lookup has reported
            wait_idle();
        end

        $display("covered %0d beats, %0d lookups checked, 6 grid/layout settings",
                 beats_sent, lookups_checked);
        $display("idle mixes 29, 48 and 0 percent; uniform, split search and fractional modes");
        if (errors == 0) begin
            $display("grid_cell_owner_lookup_core_test: PASS");
        end else begin
            $display("grid_cell_owner_lookup_core_test: FAIL");
        end
        $finish;
    end
endmodule
